// File: rtl/trws_pkg.sv
// trws_pkg: shared constants for the torque / rotation window sampler.
// No dependencies; used by torque_rotate_window_sampler_core and trws_checker.
package trws_pkg;

    // default geometry
    localparam int SLOTS_DEF        = 10;
    localparam int WINDOW_TICKS_DEF = 62500;

    // field widths
    localparam int OP_W     = 2;
    localparam int CNT8_W   = 8;
    localparam int TIMER_W  = 16;
    localparam int WORD_W   = 16;
    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 32;
    localparam int STAMP_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int IVAL_W   = 8;
    localparam int TICK_W   = 16;

    // stream and config port widths
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_PULSE = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN = 2'd2;

    // register reset values
    localparam logic [IVAL_W-1:0] SHOW_RST = 8'd1;
    localparam logic [IVAL_W-1:0] QUIT_RST = 8'd30;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;

    // gain is Q4.12
    localparam int GAIN_FRAC = 12;
    localparam int PROD_W    = STAMP_W + GAIN_W;        // 48
    localparam int DIVD_W    = PROD_W - GAIN_FRAC;      // 36

    // serial unit step counts
    localparam int MUL_STEPS = GAIN_W;                  // one gain bit per cycle
    localparam int DIV_STEPS = DIVD_W;                  // one quotient bit per cycle
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

endpackage

// File: rtl/torque_rotate_window_sampler_core.sv
// torque_rotate_window_sampler_core: top level of the torque / rotation sampler.
// Depends on trws_pkg (constants, widths, item kinds, register indexes).
//
// Usage and timing: every input item gives exactly one result item. Start, rotation
// pulse, ignored items and ticks that do not close a slot window go straight to the
// pending result registers on accept; the output register takes the result once it
// is free, and only then can the next item be taken. A tick that closes a window of
// SLOTS ticks runs a bit-serial pass (one gain bit of the period product per cycle,
// with the window-number remainders against show_interval and quit_interval worked
// out one bit per cycle in the same pass); when that tick also shows and at least two
// pulses were seen, a restoring divider follows (one quotient bit per cycle). One item
// is in work at a time; s_tready is high only when the block is free, and a finished
// result may wait in the output register while the next item is taken in. Registers
// are to be written only while the block is idle; this binds the user, and the
// block itself does nothing to enforce it. Ping-pong torque storage is left to
// the consumer: each tick result carries the word, its slot and the buffer in use.
module torque_rotate_window_sampler_core #(
    parameter int SLOTS        = trws_pkg::SLOTS_DEF,
    parameter int WINDOW_TICKS = trws_pkg::WINDOW_TICKS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config write port
    input  logic                             cfg_wen,
    input  logic [trws_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [trws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] small_count, [15:8] overflow_count, [31:16] timer_value
    input  logic [trws_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] op
    input  logic [trws_pkg::S_TUSER_W-1:0]   s_tuser,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] torque_word, [19:16] slot_index, [20] buffer_select, [21] save_event,
    // [22] show_event, [23] quit_event, [55:24] rotate_period, all from the lowest bit
    output logic [trws_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int SLOT_CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WIN_W   = trws_pkg::TICK_W;
    localparam int STAMP_W = trws_pkg::STAMP_W;
    localparam int GAIN_W  = trws_pkg::GAIN_W;
    localparam int IVAL_W  = trws_pkg::IVAL_W;
    localparam int WORD_W  = trws_pkg::WORD_W;
    localparam int PER_W   = trws_pkg::PERIOD_W;
    localparam int DIVD_W  = trws_pkg::DIVD_W;
    localparam int STEP_W  = trws_pkg::STEP_W;
    localparam int CNT8_W  = trws_pkg::CNT8_W;

    localparam logic [SLOT_CW-1:0] SLOT_LAST = SLOT_CW'(SLOTS - 1);
    localparam logic [STAMP_W-1:0] WIN_INC   = STAMP_W'(WINDOW_TICKS);
    localparam logic [STEP_W-1:0]  MUL_LAST  = STEP_W'(trws_pkg::MUL_STEPS - 1);
    localparam logic [STEP_W-1:0]  DIV_LAST  = STEP_W'(trws_pkg::DIV_STEPS - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;   // product + interval remainders
    localparam logic [1:0] ST_DIV  = 2'd2;   // period division
    localparam logic [1:0] ST_DONE = 2'd3;   // hand result to output register

    // ---------------- config registers ----------------
    logic [IVAL_W-1:0] show_ival_reg;
    logic [IVAL_W-1:0] quit_ival_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_ival_reg <= trws_pkg::SHOW_RST;
            quit_ival_reg <= trws_pkg::QUIT_RST;
            gain_reg      <= trws_pkg::GAIN_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                trws_pkg::REG_SHOW: show_ival_reg <= cfg_wdata[IVAL_W-1:0];
                trws_pkg::REG_QUIT: quit_ival_reg <= cfg_wdata[IVAL_W-1:0];
                trws_pkg::REG_GAIN: gain_reg      <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input unpack ----------------
    logic [trws_pkg::OP_W-1:0]    in_op;
    logic [CNT8_W-1:0]            in_small;
    logic [CNT8_W-1:0]            in_ovf;
    logic [trws_pkg::TIMER_W-1:0] in_timer;

    assign in_op    = s_tuser[trws_pkg::OP_W-1:0];
    assign in_small = s_tdata[7:0];
    assign in_ovf   = s_tdata[15:8];
    assign in_timer = s_tdata[31:16];

    // ---------------- state ----------------
    logic [1:0]               state_reg,   state_next;
    logic [trws_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [SLOT_CW-1:0]       slot_reg,    slot_next;     // tick mod SLOTS
    logic [WIN_W-1:0]         win_reg,     win_next;      // tick / SLOTS
    logic [STAMP_W-1:0]       base_reg,    base_next;     // WINDOW_TICKS * window
    logic                     active_reg,  active_next;
    logic [CNT8_W-1:0]        pcnt_reg,    pcnt_next;
    logic [STAMP_W-1:0]       first_reg,   first_next;
    logic [STAMP_W-1:0]       last_reg,    last_next;
    logic [PER_W-1:0]         period_reg,  period_next;
    logic                     stopped_reg, stopped_next;

    // serial datapath
    logic [STEP_W-1:0]        step_reg,    step_next;
    logic [STAMP_W-1:0]       span_reg,    span_next;
    logic [STAMP_W-1:0]       mhi_reg,     mhi_next;
    logic [GAIN_W-1:0]        mlo_reg,     mlo_next;
    logic [WIN_W-1:0]         wsh_reg,     wsh_next;      // window number, MSB out first
    logic [IVAL_W-1:0]        srem_reg,    srem_next;
    logic [IVAL_W-1:0]        qrem_reg,    qrem_next;
    logic [DIVD_W-1:0]        dq_reg,      dq_next;       // dividend in, quotient out
    logic [CNT8_W-1:0]        drem_reg,    drem_next;
    logic [CNT8_W-1:0]        den_reg,     den_next;

    // pending result
    logic [WORD_W-1:0]        rword_reg,   rword_next;
    logic [SLOT_CW-1:0]       rslot_reg,   rslot_next;
    logic                     rsave_reg,   rsave_next;
    logic                     rshow_reg,   rshow_next;
    logic                     rquit_reg,   rquit_next;

    // output register
    logic                     ovalid_reg,  ovalid_next;
    logic [WORD_W-1:0]        oword_reg,   oword_next;
    logic [trws_pkg::SLOT_W-1:0] oslot_reg, oslot_next;
    logic                     obuf_reg,    obuf_next;
    logic                     osave_reg,   osave_next;
    logic                     oshow_reg,   oshow_next;
    logic                     oquit_reg,   oquit_next;
    logic [PER_W-1:0]         oper_reg,    oper_next;

    // ---------------- step arithmetic ----------------
    logic                     accept;
    logic [WORD_W-1:0]        torque_word;
    logic [STAMP_W-1:0]       stamp;
    logic [STAMP_W:0]         mul_sum;
    logic [IVAL_W:0]          s_trial, q_trial;
    logic                     s_ge, q_ge;
    logic [CNT8_W+1:0]        d_diff;
    logic                     show_hit, quit_hit;
    logic                     out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !ovalid_reg || m_tready;

    // small + 255*ovf = small + (ovf << 8) - ovf, kept to 16 bits
    assign torque_word = WORD_W'(in_small) + {in_ovf, 8'd0} - WORD_W'(in_ovf);
    assign stamp       = STAMP_W'(in_timer) + base_reg;

    // shift-add multiply: add span when the low gain bit is set, then shift right
    assign mul_sum = {1'b0, mhi_reg} + (mlo_reg[0] ? {1'b0, span_reg} : '0);

    // restoring remainders of the window number, one bit per cycle
    assign s_trial = {srem_reg, wsh_reg[WIN_W-1]};
    assign q_trial = {qrem_reg, wsh_reg[WIN_W-1]};
    assign s_ge    = (s_trial >= {1'b0, show_ival_reg});
    assign q_ge    = (q_trial >= {1'b0, quit_ival_reg});

    // restoring divider step
    assign d_diff  = {1'b0, drem_reg, dq_reg[DIVD_W-1]} - {2'b00, den_reg};

    // remainders are final after the last multiply step
    assign show_hit = (show_ival_reg != '0) &&
                      ((s_ge ? IVAL_W'(s_trial - {1'b0, show_ival_reg})
                             : s_trial[IVAL_W-1:0]) == '0);
    assign quit_hit = (quit_ival_reg != '0) &&
                      ((q_ge ? IVAL_W'(q_trial - {1'b0, quit_ival_reg})
                             : q_trial[IVAL_W-1:0]) == '0);

    always_comb
    begin
        state_next   = state_reg;
        tick_next    = tick_reg;
        slot_next    = slot_reg;
        win_next     = win_reg;
        base_next    = base_reg;
        active_next  = active_reg;
        pcnt_next    = pcnt_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        period_next  = period_reg;
        stopped_next = stopped_reg;
        step_next    = step_reg;
        span_next    = span_reg;
        mhi_next     = mhi_reg;
        mlo_next     = mlo_reg;
        wsh_next     = wsh_reg;
        srem_next    = srem_reg;
        qrem_next    = qrem_reg;
        dq_next      = dq_reg;
        drem_next    = drem_reg;
        den_next     = den_reg;
        rword_next   = rword_reg;
        rslot_next   = rslot_reg;
        rsave_next   = rsave_reg;
        rshow_next   = rshow_reg;
        rquit_next   = rquit_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        oword_next   = oword_reg;
        oslot_next   = oslot_reg;
        obuf_next    = obuf_reg;
        osave_next   = osave_reg;
        oshow_next   = oshow_reg;
        oquit_next   = oquit_reg;
        oper_next    = oper_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rword_next = '0;
                    rslot_next = '0;
                    rsave_next = 1'b0;
                    rshow_next = 1'b0;
                    rquit_next = 1'b0;
                    state_next = ST_DONE;
                    if (in_op == trws_pkg::OP_START)
                    begin
                        tick_next    = '0;
                        slot_next    = '0;
                        win_next     = '0;
                        base_next    = '0;
                        pcnt_next    = '0;
                        first_next   = '0;
                        last_next    = '0;
                        stopped_next = 1'b0;
                    end
                    else if (in_op == trws_pkg::OP_TICK && !stopped_reg)
                    begin
                        rword_next = torque_word;
                        rslot_next = slot_reg;
                        tick_next  = tick_reg + 1'b1;
                        if (tick_reg == '1)
                        begin
                            // counter wraps to zero: new window zero, also a boundary
                            slot_next = '0;
                            win_next  = '0;
                            base_next = '0;
                        end
                        else if (slot_reg == SLOT_LAST)
                        begin
                            slot_next = '0;
                            win_next  = win_reg + 1'b1;
                            base_next = base_reg + WIN_INC;
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                        if (tick_reg == '1 || slot_reg == SLOT_LAST)
                        begin
                            active_next = !active_reg;
                            rsave_next  = 1'b1;
                            wsh_next    = (tick_reg == '1) ? '0 : win_reg + 1'b1;
                            srem_next   = '0;
                            qrem_next   = '0;
                            span_next   = last_reg - first_reg;
                            mhi_next    = '0;
                            mlo_next    = gain_reg;
                            step_next   = '0;
                            state_next  = ST_MUL;
                        end
                    end
                    else if (in_op == trws_pkg::OP_PULSE && !stopped_reg)
                    begin
                        pcnt_next = pcnt_reg + 1'b1;
                        if (pcnt_reg + 1'b1 == CNT8_W'(1))
                            first_next = stamp;
                        else
                            last_next = stamp;
                    end
                end
            end

            ST_MUL:
            begin
                mhi_next  = mul_sum[STAMP_W:1];
                mlo_next  = {mul_sum[0], mlo_reg[GAIN_W-1:1]};
                wsh_next  = {wsh_reg[WIN_W-2:0], 1'b0};
                srem_next = s_ge ? IVAL_W'(s_trial - {1'b0, show_ival_reg})
                                 : s_trial[IVAL_W-1:0];
                qrem_next = q_ge ? IVAL_W'(q_trial - {1'b0, quit_ival_reg})
                                 : q_trial[IVAL_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    rshow_next = show_hit;
                    rquit_next = quit_hit;
                    if (quit_hit)
                        stopped_next = 1'b1;
                    state_next = ST_DONE;
                    if (show_hit)
                    begin
                        if (pcnt_reg < CNT8_W'(2))
                        begin
                            period_next = '0;
                        end
                        else
                        begin
                            // product of this last step, Q4.12 fraction dropped
                            dq_next    = DIVD_W'({mul_sum[STAMP_W:1], mul_sum[0],
                                          mlo_reg[GAIN_W-1:1]} >> trws_pkg::GAIN_FRAC);
                            drem_next  = '0;
                            den_next   = pcnt_reg - 1'b1;
                            step_next  = '0;
                            state_next = ST_DIV;
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (!d_diff[CNT8_W+1])
                begin
                    drem_next = d_diff[CNT8_W-1:0];
                    dq_next   = {dq_reg[DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = {drem_reg[CNT8_W-2:0], dq_reg[DIVD_W-1]};
                    dq_next   = {dq_reg[DIVD_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    // saturate quotient to 32 bits
                    if (dq_next[DIVD_W-1:PER_W] != '0)
                        period_next = '1;
                    else
                        period_next = dq_next[PER_W-1:0];
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oword_next  = rword_reg;
                    oslot_next  = trws_pkg::SLOT_W'(rslot_reg);
                    obuf_next   = active_reg;
                    osave_next  = rsave_reg;
                    oshow_next  = rshow_reg;
                    oquit_next  = rquit_reg;
                    oper_next   = period_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            slot_reg    <= '0;
            win_reg     <= '0;
            base_reg    <= '0;
            active_reg  <= 1'b0;
            pcnt_reg    <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            period_reg  <= '0;
            stopped_reg <= 1'b1;
            step_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            slot_reg    <= slot_next;
            win_reg     <= win_next;
            base_reg    <= base_next;
            active_reg  <= active_next;
            pcnt_reg    <= pcnt_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            period_reg  <= period_next;
            stopped_reg <= stopped_next;
            step_reg    <= step_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        span_reg  <= span_next;
        mhi_reg   <= mhi_next;
        mlo_reg   <= mlo_next;
        wsh_reg   <= wsh_next;
        srem_reg  <= srem_next;
        qrem_reg  <= qrem_next;
        dq_reg    <= dq_next;
        drem_reg  <= drem_next;
        den_reg   <= den_next;
        rword_reg <= rword_next;
        rslot_reg <= rslot_next;
        rsave_reg <= rsave_next;
        rshow_reg <= rshow_next;
        rquit_reg <= rquit_next;
        oword_reg <= oword_next;
        oslot_reg <= oslot_next;
        obuf_reg  <= obuf_next;
        osave_reg <= osave_next;
        oshow_reg <= oshow_next;
        oquit_reg <= oquit_next;
        oper_reg  <= oper_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {oper_reg, oquit_reg, oshow_reg, osave_reg, obuf_reg,
                       oslot_reg, oword_reg};

endmodule

// File: rtl/trws_checker.sv
// trws_checker: port-level assertions for torque_rotate_window_sampler_core.
// Depends on trws_pkg; bound to the top level at the end of this file.
module trws_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [trws_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result holds its bits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // show and quit only land on a window boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[22] || m_tdata[23]) |-> m_tdata[21])
        else $error("show or quit without save");

endmodule

bind torque_rotate_window_sampler_core trws_checker u_trws_checker (.*);
